[rtl/kbl_pkg.sv]
`timescale 1ns / 1ps

package kbl_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int SCORE_W = 8;
   localparam int INDEX_W = 6;
   localparam int AREA_W  = 2 * COORD_W;

   // register reset value and box sentinels
   localparam logic [SCORE_W-1:0] THRESHOLD_RESET = SCORE_W'(26);
   localparam logic [COORD_W-1:0] COORD_ALL_ONES  = {COORD_W{1'b1}};
   localparam logic [COORD_W-1:0] COORD_ZERO      = {COORD_W{1'b0}};

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one closed person (or empty frame) handed from front to back
   typedef struct packed {
      logic [INDEX_W-1:0] person_index;
      logic [COORD_W-1:0] min_x;
      logic [COORD_W-1:0] min_y;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic               last_person;
      logic               empty_frame;
   } kbl_rec_type;

endpackage

[rtl/kbl_front.sv]
`timescale 1ns / 1ps

module kbl_front import kbl_pkg::*; #(
   parameter int MAX_PEOPLE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [SCORE_W-1:0] csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic [SCORE_W-1:0] req_point_score,
   input  logic               req_last_part,
   input  logic               req_last_person,
   input  logic               req_empty_frame,
   input  logic               q_full,
   output logic               q_push,
   output kbl_rec_type        q_rec
);

   localparam int CNT_W = $clog2(MAX_PEOPLE);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PEOPLE - 1);

   logic [SCORE_W-1:0] thresh_ff;
   logic [COORD_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [COORD_W-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W+INDEX_W-1:0] cnt_ext;
   logic               accept;
   logic               qualify;
   logic               box_ok;

   // take an item whenever the queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign qualify   = req_point_score > thresh_ff;

   // box widened by the current keypoint
   always_comb begin
      min_x_in = (qualify && req_point_x < min_x_ff) ? req_point_x : min_x_ff;
      max_x_in = (qualify && req_point_x > max_x_ff) ? req_point_x : max_x_ff;
      min_y_in = (qualify && req_point_y < min_y_ff) ? req_point_y : min_y_ff;
      max_y_in = (qualify && req_point_y > max_y_ff) ? req_point_y : max_y_ff;
   end

   assign box_ok  = (max_x_in >= min_x_in) && (max_y_in >= min_y_in);
   assign cnt_ext = {{INDEX_W{1'b0}}, cnt_ff};

   // closed person record
   always_comb begin
      q_push = accept && (req_empty_frame || req_last_part);
      q_rec.empty_frame  = req_empty_frame;
      q_rec.last_person  = req_last_person;
      q_rec.person_index = req_empty_frame ? {INDEX_W{1'b0}} : cnt_ext[INDEX_W-1:0];
      if (box_ok && !req_empty_frame) begin
         q_rec.min_x  = min_x_in;
         q_rec.min_y  = min_y_in;
         q_rec.width  = max_x_in - min_x_in;
         q_rec.height = max_y_in - min_y_in;
      end else begin
         q_rec.min_x  = COORD_ZERO;
         q_rec.min_y  = COORD_ZERO;
         q_rec.width  = COORD_ZERO;
         q_rec.height = COORD_ZERO;
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
      end else if (csr_write_en) begin
         thresh_ff <= csr_write_data;
      end
   end

   // running box and person counter
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= COORD_ALL_ONES;
         max_x_ff <= COORD_ZERO;
         min_y_ff <= COORD_ALL_ONES;
         max_y_ff <= COORD_ZERO;
         cnt_ff   <= '0;
      end else if (accept) begin
         if (req_empty_frame || req_last_part) begin
            min_x_ff <= COORD_ALL_ONES;
            max_x_ff <= COORD_ZERO;
            min_y_ff <= COORD_ALL_ONES;
            max_y_ff <= COORD_ZERO;
            if (req_empty_frame || req_last_person) begin
               cnt_ff <= '0;
            end else if (cnt_ff != CNT_LAST) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end else begin
            min_x_ff <= min_x_in;
            max_x_ff <= max_x_in;
            min_y_ff <= min_y_in;
            max_y_ff <= max_y_in;
         end
      end
   end

endmodule

[rtl/kbl_queue.sv]
`timescale 1ns / 1ps

module kbl_queue import kbl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  kbl_rec_type push_rec,
   input  logic        pop,
   output kbl_rec_type pop_rec,
   output logic        full,
   output logic        empty
);

   kbl_rec_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_rec = entry_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_W'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // no overflow or underflow
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

[rtl/kbl_back.sv]
`timescale 1ns / 1ps

module kbl_back import kbl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  kbl_rec_type        q_rec,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [INDEX_W-1:0] rsp_person_index,
   output logic [COORD_W-1:0] rsp_box_min_x,
   output logic [COORD_W-1:0] rsp_box_min_y,
   output logic [COORD_W-1:0] rsp_box_width,
   output logic [COORD_W-1:0] rsp_box_height,
   output logic [AREA_W-1:0]  rsp_box_area,
   output logic [INDEX_W-1:0] rsp_biggest_index,
   output logic               rsp_biggest_valid,
   output logic               rsp_frame_done
);

   logic               s1_valid_ff;
   kbl_rec_type        s1_rec_ff;
   logic [AREA_W-1:0]  s1_area_ff;
   logic               out_valid_ff;
   logic               out_free;
   logic               advance;
   logic               take;
   logic [INDEX_W-1:0] big_idx_in;

   logic [AREA_W-1:0]  best_area_ff;
   logic [INDEX_W-1:0] best_idx_ff;
   logic               have_best_ff;

   logic [INDEX_W-1:0] o_index_ff, o_big_ff;
   logic [COORD_W-1:0] o_min_x_ff, o_min_y_ff, o_width_ff, o_height_ff;
   logic [AREA_W-1:0]  o_area_ff;
   logic               o_big_valid_ff, o_done_ff;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance  = s1_valid_ff && out_free;
   assign q_pop    = !q_empty && (!s1_valid_ff || out_free);

   // largest-area decision, earlier person wins a tie
   assign take       = !have_best_ff || (s1_area_ff > best_area_ff);
   assign big_idx_in = take ? s1_rec_ff.person_index : best_idx_ff;

   // stage 1: area multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || out_free) begin
         s1_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_rec_ff  <= q_rec;
         s1_area_ff <= AREA_W'(q_rec.width) * AREA_W'(q_rec.height);
      end
   end

   // best-person tracking per frame
   always_ff @(posedge clock) begin
      if (reset) begin
         best_area_ff <= '0;
         best_idx_ff  <= '0;
         have_best_ff <= 1'b0;
      end else if (advance) begin
         if (s1_rec_ff.empty_frame || s1_rec_ff.last_person) begin
            best_area_ff <= '0;
            best_idx_ff  <= '0;
            have_best_ff <= 1'b0;
         end else if (take) begin
            best_area_ff <= s1_area_ff;
            best_idx_ff  <= s1_rec_ff.person_index;
            have_best_ff <= 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_index_ff  <= s1_rec_ff.person_index;
         o_min_x_ff  <= s1_rec_ff.min_x;
         o_min_y_ff  <= s1_rec_ff.min_y;
         o_width_ff  <= s1_rec_ff.width;
         o_height_ff <= s1_rec_ff.height;
         o_area_ff   <= s1_area_ff;
         if (s1_rec_ff.empty_frame) begin
            o_big_ff       <= '0;
            o_big_valid_ff <= 1'b0;
            o_done_ff      <= 1'b1;
         end else begin
            o_big_ff       <= big_idx_in;
            o_big_valid_ff <= 1'b1;
            o_done_ff      <= s1_rec_ff.last_person;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_person_index  = o_index_ff;
   assign rsp_box_min_x     = o_min_x_ff;
   assign rsp_box_min_y     = o_min_y_ff;
   assign rsp_box_width     = o_width_ff;
   assign rsp_box_height    = o_height_ff;
   assign rsp_box_area      = o_area_ff;
   assign rsp_biggest_index = o_big_ff;
   assign rsp_biggest_valid = o_big_valid_ff;
   assign rsp_frame_done    = o_done_ff;

   // stage 1 holds while the output is blocked
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !q_pop) else $error("stage 1 overwritten");
   // an empty-frame result carries no box and no biggest person
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !o_big_valid_ff) |-> (o_done_ff && o_area_ff == '0))
      else $error("bad empty-frame result");

endmodule

[rtl/keypoint_box_largest_person.sv]
`timescale 1ns / 1ps

// Bounding box and largest-person selector for streamed pose keypoints.
// req_ channel: one keypoint per item (x, y, score, last_part, last_person,
//   empty_frame). An item is taken at a clock edge with req_valid high and
//   req_stall low.
// rsp_ channel: one item per closed person and one per empty frame, with
//   the box, its area and the index of the largest person of the frame so far.
// csr_ port: csr_write_en writes csr_write_data to the score threshold.
// Throughput: one keypoint per cycle while req_stall is low.
// Path: a closing keypoint's record goes into a 4-entry queue, then the area
//   multiply stage, then the output register, which drives rsp_valid.
// When the receiver holds rsp_stall, the output register keeps its item,
//   the multiply stage and the queue fill, and req_stall rises once the
//   queue is full; nothing is lost or repeated.
// Reset (synchronous, active high) empties the queue and pipeline, clears
//   the running box, person counter and best-person state, and sets the
//   threshold to 26. Person indexes saturate at MAX_PEOPLE - 1.
module keypoint_box_largest_person import kbl_pkg::*; #(
   parameter int MAX_PEOPLE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [SCORE_W-1:0] csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic [SCORE_W-1:0] req_point_score,
   input  logic               req_last_part,
   input  logic               req_last_person,
   input  logic               req_empty_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [INDEX_W-1:0] rsp_person_index,
   output logic [COORD_W-1:0] rsp_box_min_x,
   output logic [COORD_W-1:0] rsp_box_min_y,
   output logic [COORD_W-1:0] rsp_box_width,
   output logic [COORD_W-1:0] rsp_box_height,
   output logic [AREA_W-1:0]  rsp_box_area,
   output logic [INDEX_W-1:0] rsp_biggest_index,
   output logic               rsp_biggest_valid,
   output logic               rsp_frame_done
);

   logic        q_push, q_pop, q_full, q_empty;
   kbl_rec_type push_rec, pop_rec;

   // keypoint intake and box tracking
   kbl_front #(.MAX_PEOPLE(MAX_PEOPLE)) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_score (req_point_score),
      .req_last_part   (req_last_part),
      .req_last_person (req_last_person),
      .req_empty_frame (req_empty_frame),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_rec           (push_rec)
   );

   // decoupling queue
   kbl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .pop      (q_pop),
      .pop_rec  (pop_rec),
      .full     (q_full),
      .empty    (q_empty)
   );

   // area and largest-person selection
   kbl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_rec             (pop_rec),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_person_index  (rsp_person_index),
      .rsp_box_min_x     (rsp_box_min_x),
      .rsp_box_min_y     (rsp_box_min_y),
      .rsp_box_width     (rsp_box_width),
      .rsp_box_height    (rsp_box_height),
      .rsp_box_area      (rsp_box_area),
      .rsp_biggest_index (rsp_biggest_index),
      .rsp_biggest_valid (rsp_biggest_valid),
      .rsp_frame_done    (rsp_frame_done)
   );

endmodule

[tb/tb_keypoint_box_largest_person.sv]
`timescale 1ns / 1ps

module tb_keypoint_box_largest_person;
   import kbl_pkg::*;

   localparam int HALF_PERIOD        = 10;
   localparam int PERSON_LIMIT       = 64;
   localparam int RESET_CYCLES       = 11;
   localparam int SETTING_COUNT      = 6;
   localparam int RANDOM_PER_SETTING = 240;
   localparam int SETTLE_CYCLES      = 8;
   localparam int QUIET_LIMIT        = 2000;
   localparam int HOLD_CYCLES        = 150;
   localparam int HOLD_SPACING       = 250;
   localparam int HOLD_COUNT         = 3;
   localparam int REPORT_LIMIT       = 40;

   // one keypoint as offered on the request side
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [SCORE_W-1:0] score;
      logic               last_part;
      logic               last_person;
      logic               empty_frame;
   } keypoint_type;

   // one box result as seen on the response side
   typedef struct packed {
      logic [INDEX_W-1:0] person_index;
      logic [COORD_W-1:0] min_x;
      logic [COORD_W-1:0] min_y;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic [AREA_W-1:0]  area;
      logic [INDEX_W-1:0] biggest_index;
      logic               biggest_valid;
      logic               frame_done;
   } box_result_type;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [SCORE_W-1:0] csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [COORD_W-1:0] req_point_x;
   logic [COORD_W-1:0] req_point_y;
   logic [SCORE_W-1:0] req_point_score;
   logic               req_last_part;
   logic               req_last_person;
   logic               req_empty_frame;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [INDEX_W-1:0] rsp_person_index;
   logic [COORD_W-1:0] rsp_box_min_x;
   logic [COORD_W-1:0] rsp_box_min_y;
   logic [COORD_W-1:0] rsp_box_width;
   logic [COORD_W-1:0] rsp_box_height;
   logic [AREA_W-1:0]  rsp_box_area;
   logic [INDEX_W-1:0] rsp_biggest_index;
   logic               rsp_biggest_valid;
   logic               rsp_frame_done;

   keypoint_type   keypoint_pending_q[$];
   box_result_type box_expect_q[$];

   // box tracker state mirrored from the block
   logic [SCORE_W-1:0] score_thr;
   logic [COORD_W-1:0] run_min_x, run_max_x, run_min_y, run_max_y;
   logic [INDEX_W-1:0] person_count;
   logic [AREA_W-1:0]  best_area;
   logic [INDEX_W-1:0] best_index;
   logic               have_best;

   logic req_taken;
   int   items_queued;
   int   points_taken;
   int   boxes_seen;
   int   frames_closed;
   int   empty_frames_seen;
   int   saturated_boxes;
   int   settings_used;
   int   mismatch_count;
   int   quiet_cycles;
   int   burst_left;
   int   gap_left;
   int   hold_left;
   int   holds_done;
   int   pattern_left;
   int   stall_pct;

   keypoint_box_largest_person #(
      .MAX_PEOPLE(PERSON_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_score  (req_point_score),
      .req_last_part    (req_last_part),
      .req_last_person  (req_last_person),
      .req_empty_frame  (req_empty_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_person_index (rsp_person_index),
      .rsp_box_min_x    (rsp_box_min_x),
      .rsp_box_min_y    (rsp_box_min_y),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .rsp_box_area     (rsp_box_area),
      .rsp_biggest_index(rsp_biggest_index),
      .rsp_biggest_valid(rsp_biggest_valid),
      .rsp_frame_done   (rsp_frame_done)
   );

   // clock
   always #HALF_PERIOD clock = ~clock;

   // start a fresh person box
   task automatic clear_person_box();
      run_min_x = COORD_ALL_ONES;
      run_max_x = COORD_ZERO;
      run_min_y = COORD_ALL_ONES;
      run_max_y = COORD_ZERO;
   endtask

   // start a fresh frame
   task automatic clear_frame_state();
      clear_person_box();
      person_count = '0;
      best_area    = '0;
      best_index   = '0;
      have_best    = 1'b0;
   endtask

   // fold one accepted keypoint into the box tracker, queue any box it closes
   task automatic track_keypoint(input keypoint_type kp);
      box_result_type box;
      box = '0;
      if (kp.empty_frame) begin
         clear_frame_state();
         box.frame_done = 1'b1;
         box_expect_q.push_back(box);
         empty_frames_seen++;
      end else begin
         if (kp.score > score_thr) begin
            if (kp.x > run_max_x) run_max_x = kp.x;
            if (kp.x < run_min_x) run_min_x = kp.x;
            if (kp.y > run_max_y) run_max_y = kp.y;
            if (kp.y < run_min_y) run_min_y = kp.y;
         end
         if (kp.last_part) begin
            // box stays all zero when nothing qualified
            if (run_max_x >= run_min_x && run_max_y >= run_min_y) begin
               box.min_x  = run_min_x;
               box.min_y  = run_min_y;
               box.width  = run_max_x - run_min_x;
               box.height = run_max_y - run_min_y;
               box.area   = AREA_W'(box.width) * AREA_W'(box.height);
            end
            // ties keep the earlier person
            if (!have_best || box.area > best_area) begin
               best_area  = box.area;
               best_index = person_count;
               have_best  = 1'b1;
            end
            box.person_index  = person_count;
            box.biggest_index = best_index;
            box.biggest_valid = 1'b1;
            box.frame_done    = kp.last_person;
            box_expect_q.push_back(box);
            if (person_count == INDEX_W'(PERSON_LIMIT - 1)) saturated_boxes++;
            if (kp.last_person) begin
               clear_frame_state();
               frames_closed++;
            end else begin
               clear_person_box();
               if (person_count < INDEX_W'(PERSON_LIMIT - 1)) person_count++;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   function automatic keypoint_type make_point(input int x, input int y, input int score,
                                               input bit last_part, input bit last_person,
                                               input bit empty_frame);
      keypoint_type kp;
      kp.x           = COORD_W'(x);
      kp.y           = COORD_W'(y);
      kp.score       = SCORE_W'(score);
      kp.last_part   = last_part;
      kp.last_person = last_person;
      kp.empty_frame = empty_frame;
      return kp;
   endfunction

   task automatic push_point(input keypoint_type kp);
      keypoint_pending_q.push_back(kp);
      items_queued++;
   endtask

   // empty frame marker with junk in the ignored fields
   function automatic keypoint_type random_empty();
      return make_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'b1);
   endfunction

   // scores spread over the range and clustered around the threshold
   function automatic logic [SCORE_W-1:0] pick_score(input logic [SCORE_W-1:0] thr);
      int s;
      case ($urandom_range(0, 3))
         0: s = $urandom_range(0, 255);
         1: s = int'(thr) + int'($urandom_range(0, 4)) - 2;
         2: s = $urandom_range(int'(thr), 255);
         default: s = ($urandom_range(0, 1) != 0) ? 255 : 0;
      endcase
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return SCORE_W'(s);
   endfunction

   // full range, tight cluster near a base, or the range ends
   function automatic logic [COORD_W-1:0] pick_coord(input int base, input int mode);
      int c;
      case (mode)
         0: c = $urandom_range(0, 65535);
         1: begin
            c = base + int'($urandom_range(0, 300));
            if (c > 65535) c = 65535;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: c = 0;
               1: c = 1;
               2: c = 65534;
               default: c = 65535;
            endcase
         end
      endcase
      return COORD_W'(c);
   endfunction

   task automatic queue_person(input int n_points, input bit closes_frame,
                               input logic [SCORE_W-1:0] thr);
      int           mode;
      int           base_x;
      int           base_y;
      int           i;
      keypoint_type kp;
      mode   = $urandom_range(0, 2);
      base_x = $urandom_range(0, 65535);
      base_y = $urandom_range(0, 65535);
      for (i = 0; i < n_points; i++) begin
         kp.x           = pick_coord(base_x, mode);
         kp.y           = pick_coord(base_y, mode);
         kp.score       = pick_score(thr);
         kp.last_part   = (i == n_points - 1);
         // last_person on an inner keypoint must be ignored
         kp.last_person = kp.last_part ? closes_frame : ($urandom_range(0, 9) == 0);
         kp.empty_frame = 1'b0;
         push_point(kp);
      end
   endtask

   // one frame: mostly well formed, sometimes empty or cut by an empty frame
   task automatic queue_frame(input logic [SCORE_W-1:0] thr, input bit crowd);
      int n_people;
      int n_cut;
      int p;
      int i;
      if (!crowd && $urandom_range(0, 9) == 0) begin
         push_point(random_empty());
      end else begin
         n_people = crowd ? $urandom_range(PERSON_LIMIT, PERSON_LIMIT + 6)
                          : $urandom_range(1, 5);
         for (p = 0; p < n_people; p++) begin
            if (!crowd && $urandom_range(0, 29) == 0) begin
               n_cut = $urandom_range(1, 3);
               for (i = 0; i < n_cut; i++)
                  push_point(make_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                                        int'(pick_score(thr)), 1'b0,
                                        1'($urandom_range(0, 1)), 1'b0));
               push_point(random_empty());
               return;
            end
            queue_person(crowd ? $urandom_range(1, 2) : $urandom_range(1, 8),
                         p == n_people - 1, thr);
         end
      end
   endtask

   // wait until everything offered was taken and every box came back
   task automatic wait_until_idle();
      while (keypoint_pending_q.size() != 0 || req_valid || box_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // request driver: bursts with gaps, payload held while stalled
   always @(negedge clock) begin : request_driver
      keypoint_type kp;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (keypoint_pending_q.size() != 0) begin
            kp = keypoint_pending_q.pop_front();
            req_valid       <= 1'b1;
            req_point_x     <= kp.x;
            req_point_y     <= kp.y;
            req_point_score <= kp.score;
            req_last_part   <= kp.last_part;
            req_last_person <= kp.last_person;
            req_empty_frame <= kp.empty_frame;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver: changing stall pattern plus a few long holds
   always @(negedge clock) begin : response_receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done < HOLD_COUNT &&
             points_taken >= HOLD_SPACING * (holds_done + 1)) begin
            hold_left  = HOLD_CYCLES;
            holds_done = holds_done + 1;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(100, 300);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 15;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end else begin
            pattern_left = pattern_left - 1;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // monitor: check boxes against the oldest expectation, track taken keypoints
   always @(posedge clock) begin : monitor
      box_result_type want;
      keypoint_type   kp;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            boxes_seen++;
            if (box_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected box, expected none, actual index %0d area %0h",
                           $time, rsp_person_index, rsp_box_area);
            end else begin
               want = box_expect_q.pop_front();
               check_field("person_index", 32'(want.person_index), 32'(rsp_person_index));
               check_field("box_min_x", 32'(want.min_x), 32'(rsp_box_min_x));
               check_field("box_min_y", 32'(want.min_y), 32'(rsp_box_min_y));
               check_field("box_width", 32'(want.width), 32'(rsp_box_width));
               check_field("box_height", 32'(want.height), 32'(rsp_box_height));
               check_field("box_area", want.area, rsp_box_area);
               check_field("biggest_index", 32'(want.biggest_index),
                           32'(rsp_biggest_index));
               check_field("biggest_valid", 32'(want.biggest_valid),
                           32'(rsp_biggest_valid));
               check_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
            end
         end
         if (req_valid && !req_stall) begin
            kp.x           = req_point_x;
            kp.y           = req_point_y;
            kp.score       = req_point_score;
            kp.last_part   = req_last_part;
            kp.last_person = req_last_person;
            kp.empty_frame = req_empty_frame;
            track_keypoint(kp);
            points_taken++;
         end
         req_taken <= req_valid && !req_stall;
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d boxes still expected",
                  $time, quiet_cycles, box_expect_q.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus: directed frames, then random frames under several thresholds
   initial begin : stimulus
      logic [SCORE_W-1:0] thr_plan [SETTING_COUNT];
      int                 target;
      int                 p;
      clock           = 1'b0;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_write_data  = '0;
      req_valid       = 1'b0;
      req_point_x     = '0;
      req_point_y     = '0;
      req_point_score = '0;
      req_last_part   = 1'b0;
      req_last_person = 1'b0;
      req_empty_frame = 1'b0;
      rsp_stall       = 1'b0;
      req_taken       = 1'b0;
      score_thr       = THRESHOLD_RESET;
      clear_frame_state();
      thr_plan = '{THRESHOLD_RESET, SCORE_W'(0), SCORE_W'(255), SCORE_W'(200),
                   SCORE_W'($urandom_range(0, 255)), SCORE_W'(1)};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (p = 0; p < SETTING_COUNT; p++) begin
         if (p != 0) begin
            @(negedge clock);
            csr_write_en   <= 1'b1;
            csr_write_data <= thr_plan[p];
            score_thr = thr_plan[p];
            @(negedge clock);
            csr_write_en <= 1'b0;
         end
         settings_used++;

         if (p == 0) begin
            // empty frame on its own
            push_point(make_point(0, 0, 0, 0, 0, 1));
            // full-range box from the coordinate extremes
            push_point(make_point(0, 0, 255, 0, 0, 0));
            push_point(make_point(65535, 65535, 255, 1, 0, 0));
            // score equal to threshold does not count, one above does
            push_point(make_point(100, 200, 26, 0, 0, 0));
            push_point(make_point(50, 60, 27, 1, 0, 0));
            // no qualifying keypoint gives an all-zero box
            push_point(make_point(5, 5, 0, 1, 0, 0));
            // same area as the first person: earlier one kept
            push_point(make_point(0, 0, 255, 0, 0, 0));
            push_point(make_point(65535, 65535, 200, 1, 0, 0));
            // last_person on an inner keypoint is ignored, then closes frame
            push_point(make_point(10, 10, 100, 0, 1, 0));
            push_point(make_point(20, 30, 100, 1, 1, 0));
            // partial person dropped by an empty frame with junk fields
            push_point(make_point(1, 2, 200, 0, 0, 0));
            push_point(make_point(65535, 65535, 255, 1, 1, 1));
            // zero-area first person is biggest until a real box arrives
            push_point(make_point(7, 7, 0, 1, 0, 0));
            push_point(make_point(1, 1, 100, 0, 0, 0));
            push_point(make_point(3, 5, 100, 1, 1, 0));
         end

         // a crowd frame pushes the person index into saturation
         if (p % 2 == 0) queue_frame(score_thr, 1'b1);
         target = items_queued + RANDOM_PER_SETTING;
         while (items_queued < target) queue_frame(score_thr, 1'b0);
         wait_until_idle();
      end

      $display("run covered %0d keypoints, %0d boxes, %0d closed and %0d empty frames,",
               points_taken, boxes_seen, frames_closed, empty_frames_seen);
      $display("%0d thresholds, %0d boxes at the saturated person index, %0d long holds",
               settings_used, saturated_boxes, holds_done);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
